### design/lgpa_pkg.sv
// Package for the levels and gamma pixel adjuster: payload types, register
// indexes, fixed-point constants and elaboration-time coefficient functions.
// No dependencies.
package lgpa_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] IDX_IN_BLACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_IN_WHITE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_GAMMA_Q8  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_OUT_BLACK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_OUT_WHITE = 3'd4;

    localparam logic [7:0]  IN_BLACK_RST  = 8'd0;
    localparam logic [7:0]  IN_WHITE_RST  = 8'd255;
    localparam logic [11:0] GAMMA_Q8_RST  = 12'd256;
    localparam logic [7:0]  OUT_BLACK_RST = 8'd0;
    localparam logic [7:0]  OUT_WHITE_RST = 8'd255;

    // Inverse gamma in Q4.12, worked out from 2^20 plus half the divisor.
    localparam int INV_W      = 16;
    localparam int INV_FRAC   = 12;
    localparam int INV_NUM_W  = 21;
    localparam int INV_CNT_W  = 5;
    localparam logic [11:0]      GAMMA_MIN = 12'd3;
    localparam logic [INV_W-1:0] INV_MAX   = 16'hFFFF;
    localparam logic [INV_W-1:0] INV_RST   = 16'd4096;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pix_out_t;

    // Settings shared by all lanes, derived from the registers.
    typedef struct packed {
        logic [7:0]       in_black;
        logic [8:0]       in_white;
        logic [8:0]       in_range;
        logic [INV_W-1:0] inv;
        logic [7:0]       out_black;
        logic [7:0]       out_diff;
        logic             invert;
    } lane_cfg_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bitv;
        x    = x_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Coefficient 2^(-2^-idx) with f fraction bits, by repeated square roots.
    function automatic logic [63:0] exp_coef(input int f, input int idx);
        logic [63:0] c;
        c = 64'd1 << (f - 1);
        for (int j = 1; j <= idx; j++) begin
            c = isqrt64(c << f);
        end
        return c;
    endfunction

    function automatic int lane_latency(input int f);
        return 3 * f + 6;
    endfunction

endpackage

### design/lgpa_inv_div.sv
// Iterative divider that forms the Q4.12 inverse of the gamma register.
// Depends on lgpa_pkg.
module lgpa_inv_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [11:0]                     gamma_q8,
    output logic [lgpa_pkg::INV_W-1:0]      inv
);

    localparam int NW = lgpa_pkg::INV_NUM_W;

    logic                              busy_reg, busy_next;
    logic [lgpa_pkg::INV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [NW-1:0]                     num_reg, num_next;
    logic [11:0]                       den_reg, den_next;
    logic [11:0]                       rem_reg, rem_next;
    logic [NW-1:0]                     quo_reg, quo_next;
    logic [lgpa_pkg::INV_W-1:0]        inv_reg, inv_next;
    logic [12:0]                       rem_s;
    logic                              ge;
    logic [11:0]                       g_eff;

    assign g_eff = (gamma_q8 < lgpa_pkg::GAMMA_MIN) ? lgpa_pkg::GAMMA_MIN : gamma_q8;
    assign rem_s = {rem_reg, num_reg[NW-1]};
    assign ge    = rem_s >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        inv_next  = inv_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = (NW'(1) << 20) + NW'(g_eff >> 1);
            den_next  = g_eff;
            rem_next  = '0;
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next = ge ? 12'(rem_s - {1'b0, den_reg}) : rem_s[11:0];
            quo_next = {quo_reg[NW-2:0], ge};
            num_next = {num_reg[NW-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == lgpa_pkg::INV_CNT_W'(NW - 1)) begin
                busy_next = 1'b0;
                inv_next  = (quo_next > NW'(lgpa_pkg::INV_MAX))
                          ? lgpa_pkg::INV_MAX : quo_next[lgpa_pkg::INV_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            inv_reg  <= lgpa_pkg::INV_RST;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            inv_reg  <= inv_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign inv = inv_reg;

endmodule

### design/lgpa_lane.sv
// One colour channel: normalising divider, log2 by squaring, scaling by the
// inverse gamma, exp2 by coefficient products and the output level mapping.
// Depends on lgpa_pkg.
module lgpa_lane #(
    parameter int FRAC_BITS = lgpa_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  adv,
    input  logic [7:0]            pix,
    input  lgpa_pkg::lane_cfg_t   cfg,
    output logic [7:0]            pix_out
);

    localparam int F    = FRAC_BITS;
    localparam int CW   = $clog2(F + 1);
    localparam int MAGW = F + CW;
    localparam int PW   = MAGW + lgpa_pkg::INV_W;
    localparam int IPW  = PW - lgpa_pkg::INV_FRAC - F;
    localparam int YW   = F + 9;
    localparam logic [F:0] ONE = (F + 1)'(1) << F;

    typedef struct packed {
        logic zero;
        logic one;
    } flg_t;

    // Entry stage: range checks and the offset above black.
    logic [8:0] pre_rem_reg;
    flg_t       pre_flg_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pre_rem_reg      <= 9'({1'b0, pix} - {1'b0, cfg.in_black});
            pre_flg_reg.zero <= pix <= cfg.in_black;
            pre_flg_reg.one  <= {1'b0, pix} >= cfg.in_white;
        end
    end

    // Restoring division, one quotient bit per stage.
    logic [8:0]   div_rem_reg [1:F];
    logic [F-1:0] div_q_reg   [1:F];
    flg_t         div_flg_reg [1:F];
    logic [8:0]   div_rem_in  [1:F];
    logic [F-1:0] div_q_in    [1:F];
    flg_t         div_flg_in  [1:F];

    genvar j;
    generate
        for (j = 1; j <= F; j++) begin : g_div
            logic [9:0]   rem_s;
            logic         ge;
            logic [8:0]   rem_next;
            logic [F-1:0] q_next;

            if (j == 1) begin : g_first
                assign div_rem_in[j] = pre_rem_reg;
                assign div_q_in[j]   = '0;
                assign div_flg_in[j] = pre_flg_reg;
            end else begin : g_rest
                assign div_rem_in[j] = div_rem_reg[j-1];
                assign div_q_in[j]   = div_q_reg[j-1];
                assign div_flg_in[j] = div_flg_reg[j-1];
            end

            assign rem_s    = {div_rem_in[j], 1'b0};
            assign ge       = rem_s >= {1'b0, cfg.in_range};
            assign rem_next = ge ? 9'(rem_s - {1'b0, cfg.in_range}) : rem_s[8:0];
            assign q_next   = {div_q_in[j][F-2:0], ge};

            always_ff @(posedge aclk) begin
                if (adv) begin
                    div_rem_reg[j] <= rem_next;
                    div_q_reg[j]   <= q_next;
                    div_flg_reg[j] <= div_flg_in[j];
                end
            end
        end
    endgenerate

    // Leading one gives the integer part of the log and normalises the mantissa.
    logic [F-1:0]  nq;
    logic [CW-1:0] lz_k;
    logic [CW-1:0] lp_cnt_next;
    logic [F:0]    lp_m_next;
    flg_t          lp_flg_next;
    logic [F:0]    lp_m_reg;
    logic [CW-1:0] lp_cnt_reg;
    flg_t          lp_flg_reg;

    assign nq = div_q_reg[F];

    always_comb begin
        lz_k = '0;
        for (int i = 0; i < F; i++) begin
            if (nq[i]) begin
                lz_k = CW'(i);
            end
        end
        lp_cnt_next      = CW'(F) - lz_k;
        lp_m_next        = {1'b0, nq} << lp_cnt_next;
        lp_flg_next.one  = div_flg_reg[F].one;
        lp_flg_next.zero = div_flg_reg[F].zero
                         | (!div_flg_reg[F].one && (nq == '0));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lp_m_reg   <= lp_m_next;
            lp_cnt_reg <= lp_cnt_next;
            lp_flg_reg <= lp_flg_next;
        end
    end

    // Fraction bits of the log, one squaring per stage.
    logic [F:0]    sq_m_reg   [1:F];
    logic [F-1:0]  sq_fr_reg  [1:F];
    logic [CW-1:0] sq_cnt_reg [1:F];
    flg_t          sq_flg_reg [1:F];
    logic [F:0]    sq_m_in    [1:F];
    logic [F-1:0]  sq_fr_in   [1:F];
    logic [CW-1:0] sq_cnt_in  [1:F];
    flg_t          sq_flg_in  [1:F];

    generate
        for (j = 1; j <= F; j++) begin : g_sq
            logic [2*F+1:0] sqr;
            logic [F+1:0]   sh;
            logic           big;
            logic [F:0]     m_next;

            if (j == 1) begin : g_first
                assign sq_m_in[j]   = lp_m_reg;
                assign sq_fr_in[j]  = '0;
                assign sq_cnt_in[j] = lp_cnt_reg;
                assign sq_flg_in[j] = lp_flg_reg;
            end else begin : g_rest
                assign sq_m_in[j]   = sq_m_reg[j-1];
                assign sq_fr_in[j]  = sq_fr_reg[j-1];
                assign sq_cnt_in[j] = sq_cnt_reg[j-1];
                assign sq_flg_in[j] = sq_flg_reg[j-1];
            end

            assign sqr    = (2*F+2)'(sq_m_in[j]) * (2*F+2)'(sq_m_in[j]);
            assign sh     = sqr[2*F+1:F];
            assign big    = sh[F+1];
            assign m_next = big ? sh[F+1:1] : sh[F:0];

            always_ff @(posedge aclk) begin
                if (adv) begin
                    sq_m_reg[j]   <= m_next;
                    sq_fr_reg[j]  <= {sq_fr_in[j][F-2:0], big};
                    sq_cnt_reg[j] <= sq_cnt_in[j];
                    sq_flg_reg[j] <= sq_flg_in[j];
                end
            end
        end
    endgenerate

    // Magnitude of the log, then scaled by the inverse gamma.
    logic [MAGW-1:0] mag_reg;
    flg_t            mag_flg_reg;
    logic [PW-1:0]   e_reg;
    flg_t            e_flg_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_reg     <= {sq_cnt_reg[F], {F{1'b0}}} - {{CW{1'b0}}, sq_fr_reg[F]};
            mag_flg_reg <= sq_flg_reg[F];
            e_reg       <= PW'(mag_reg) * PW'(cfg.inv);
            e_flg_reg   <= mag_flg_reg;
        end
    end

    // exp2 of the negated fraction, one coefficient per stage.
    logic [F:0]     ex_r_reg   [1:F];
    logic [F-1:0]   ex_f_reg   [1:F];
    logic [IPW-1:0] ex_ip_reg  [1:F];
    flg_t           ex_flg_reg [1:F];
    logic [F:0]     ex_r_in    [1:F];
    logic [F-1:0]   ex_f_in    [1:F];
    logic [IPW-1:0] ex_ip_in   [1:F];
    flg_t           ex_flg_in  [1:F];

    generate
        for (j = 1; j <= F; j++) begin : g_exp
            localparam logic [63:0] COEF = lgpa_pkg::exp_coef(F, j);
            logic [2*F:0] prod;
            logic [F:0]   r_next;

            if (j == 1) begin : g_first
                assign ex_r_in[j]   = ONE;
                assign ex_f_in[j]   = e_reg[lgpa_pkg::INV_FRAC+F-1:lgpa_pkg::INV_FRAC];
                assign ex_ip_in[j]  = e_reg[PW-1:lgpa_pkg::INV_FRAC+F];
                assign ex_flg_in[j] = e_flg_reg;
            end else begin : g_rest
                assign ex_r_in[j]   = ex_r_reg[j-1];
                assign ex_f_in[j]   = ex_f_reg[j-1];
                assign ex_ip_in[j]  = ex_ip_reg[j-1];
                assign ex_flg_in[j] = ex_flg_reg[j-1];
            end

            assign prod   = (2*F+1)'(ex_r_in[j]) * (2*F+1)'(COEF[F-1:0]);
            assign r_next = ex_f_in[j][F-j] ? prod[2*F:F] : ex_r_in[j];

            always_ff @(posedge aclk) begin
                if (adv) begin
                    ex_r_reg[j]   <= r_next;
                    ex_f_reg[j]   <= ex_f_in[j];
                    ex_ip_reg[j]  <= ex_ip_in[j];
                    ex_flg_reg[j] <= ex_flg_in[j];
                end
            end
        end
    endgenerate

    // Power result with the end points and underflow, then the level mapping.
    logic [F:0]    p_next;
    logic [F:0]    p_reg;
    logic [YW-1:0] prod_reg;
    logic [YW-1:0] y;

    always_comb begin
        if (ex_flg_reg[F].zero) begin
            p_next = '0;
        end else if (ex_flg_reg[F].one) begin
            p_next = ONE;
        end else if (ex_ip_reg[F] > IPW'(F)) begin
            p_next = '0;
        end else begin
            p_next = ex_r_reg[F] >> ex_ip_reg[F];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg    <= p_next;
            prod_reg <= YW'(p_reg) * YW'(cfg.out_diff);
        end
    end

    assign y = cfg.invert ? YW'({cfg.out_black, {F{1'b0}}}) - prod_reg
                          : YW'({cfg.out_black, {F{1'b0}}}) + prod_reg;
    assign pix_out = y[F+7:F];

endmodule

### design/levels_gamma_pixel_adjust.sv
// Top level of the levels and gamma pixel adjuster: registers, inverse gamma
// divider, three channel lanes and the merging output register.
// Depends on lgpa_pkg, lgpa_inv_div and lgpa_lane.
//
//   Port group  Direction  Handshake            Payload
//   s_*         in         s_valid / s_ready    s_data  (pix_in_t)
//   m_*         out        m_valid / m_ready    m_data  (pix_out_t)
//   cfg_*       in         cfg_wr_en            cfg_addr, cfg_wdata
//
// One pixel is taken per clock while the pipeline is not held; each pixel
// passes the normalising divider, the log2 squarings and the exp2
// products, one stage each per fraction bit, plus the output register.
// The whole pipeline holds while a result waits and m_ready is low.
// A write to the gamma register starts, in the cycle after, the divider on
// the stored value; its result is first needed at the inverse gamma scaling
// stage, so with the default FRAC_BITS pixels may follow the write at once.
// Reset is synchronous and restores the registers.
module levels_gamma_pixel_adjust #(
    parameter int FRAC_BITS = lgpa_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lgpa_pkg::pix_in_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lgpa_pkg::pix_out_t                  m_data,
    input  logic                                cfg_wr_en,
    input  logic [lgpa_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [lgpa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int LAT = lgpa_pkg::lane_latency(FRAC_BITS);

    logic [7:0]  in_black_reg;
    logic [7:0]  in_white_reg;
    logic [11:0] gamma_q8_reg;
    logic [7:0]  out_black_reg;
    logic [7:0]  out_white_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_black_reg  <= lgpa_pkg::IN_BLACK_RST;
            in_white_reg  <= lgpa_pkg::IN_WHITE_RST;
            gamma_q8_reg  <= lgpa_pkg::GAMMA_Q8_RST;
            out_black_reg <= lgpa_pkg::OUT_BLACK_RST;
            out_white_reg <= lgpa_pkg::OUT_WHITE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                lgpa_pkg::IDX_IN_BLACK:  in_black_reg  <= cfg_wdata[7:0];
                lgpa_pkg::IDX_IN_WHITE:  in_white_reg  <= cfg_wdata[7:0];
                lgpa_pkg::IDX_GAMMA_Q8:  gamma_q8_reg  <= cfg_wdata;
                lgpa_pkg::IDX_OUT_BLACK: out_black_reg <= cfg_wdata[7:0];
                lgpa_pkg::IDX_OUT_WHITE: out_white_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    logic [lgpa_pkg::INV_W-1:0] inv;
    logic                       inv_start_reg;

    // The divider starts once the new gamma value sits in its register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_start_reg <= 1'b0;
        end else begin
            inv_start_reg <= cfg_wr_en && (cfg_addr == lgpa_pkg::IDX_GAMMA_Q8);
        end
    end

    lgpa_inv_div u_inv_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (inv_start_reg),
        .gamma_q8 (gamma_q8_reg),
        .inv      (inv)
    );

    // A white level not above black is taken as one above black.
    lgpa_pkg::lane_cfg_t lane_cfg;
    logic [8:0]          white_eff;

    assign white_eff = (in_white_reg <= in_black_reg) ? ({1'b0, in_black_reg} + 9'd1)
                                                      : {1'b0, in_white_reg};

    always_comb begin
        lane_cfg.in_black  = in_black_reg;
        lane_cfg.in_white  = white_eff;
        lane_cfg.in_range  = white_eff - {1'b0, in_black_reg};
        lane_cfg.inv       = inv;
        lane_cfg.out_black = out_black_reg;
        lane_cfg.invert    = out_white_reg < out_black_reg;
        lane_cfg.out_diff  = lane_cfg.invert ? (out_black_reg - out_white_reg)
                                             : (out_white_reg - out_black_reg);
    end

    logic adv;
    logic m_valid_reg;
    logic [LAT-1:0] vld_reg;
    lgpa_pkg::pix_out_t m_data_reg, m_data_next;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    logic [7:0] lane_in  [0:2];
    logic [7:0] lane_out [0:2];

    assign lane_in[0] = s_data.red_in;
    assign lane_in[1] = s_data.green_in;
    assign lane_in[2] = s_data.blue_in;

    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_lane
            lgpa_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
                .aclk    (aclk),
                .adv     (adv),
                .pix     (lane_in[c]),
                .cfg     (lane_cfg),
                .pix_out (lane_out[c])
            );
        end
    endgenerate

    always_comb begin
        m_data_next.red_out   = lane_out[0];
        m_data_next.green_out = lane_out[1];
        m_data_next.blue_out  = lane_out[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[LAT-2:0], s_valid};
            m_valid_reg <= vld_reg[LAT-1];
        end
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### tb/levels_gamma_pixel_adjust_check.sv
// Checker for the levels and gamma pixel adjuster: follows the register port,
// predicts each output pixel from the accepted input pixel and compares.
// Depends on lgpa_pkg for the payload types and register indexes.
module levels_gamma_pixel_adjust_check (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  lgpa_pkg::pix_in_t               s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  lgpa_pkg::pix_out_t              m_data,
    input  logic                            cfg_wr_en,
    input  logic [lgpa_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [lgpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              errors,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lgpa_pkg::*;

    localparam int FB = 16;
    localparam logic [63:0] UNITY = 64'd1 << FB;

    logic [7:0]  lv_in_black, lv_in_white, lv_out_black, lv_out_white;
    logic [11:0] lv_gamma;
    logic [63:0] halving_coef [1:FB];
    pix_out_t    pixels_due [$];

    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] r, t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    // n strictly between zero and one; returns n raised to inv/4096.
    function automatic logic [63:0] power_of(input logic [63:0] n, input logic [63:0] inv);
        int          lead;
        logic [63:0] m, lg_frac, mag, e, ip, f, r;
        lead = 0;
        lg_frac = '0;
        for (int i = 0; i < FB; i++) if (n[i]) lead = i;
        m = n << (FB - lead);
        for (int i = 0; i < FB; i++) begin
            m = (m * m) >> FB;
            lg_frac = lg_frac << 1;
            if (m >= (UNITY << 1)) begin
                m = m >> 1;
                lg_frac[0] = 1'b1;
            end
        end
        mag = (64'(FB - lead) << FB) - lg_frac;
        e = (mag * inv) >> 12;
        ip = e >> FB;
        if (ip > FB) return '0;
        f = e & (UNITY - 1);
        r = UNITY;
        for (int i = 1; i <= FB; i++) if (f[FB-i]) r = (r * halving_coef[i]) >> FB;
        return r >> ip;
    endfunction

    function automatic logic [7:0] adjust_channel(input logic [7:0] v, input logic [8:0] ib,
                                                  input logic [8:0] iw, input logic [63:0] inv);
        logic [63:0] n, p, y;
        if (v <= ib) n = 0;
        else if (v >= iw) n = UNITY;
        else n = (64'(v - ib) << FB) / 64'(iw - ib);
        if (n == 0) p = 0;
        else if (n >= UNITY) p = UNITY;
        else p = power_of(n, inv);
        if (lv_out_white >= lv_out_black)
            y = (64'(lv_out_black) << FB) + p * 64'(lv_out_white - lv_out_black);
        else
            y = (64'(lv_out_black) << FB) - p * 64'(lv_out_black - lv_out_white);
        y = y >> FB;
        if (y > 255) y = 255;
        return y[7:0];
    endfunction

    function automatic pix_out_t adjust_pixel(input pix_in_t px);
        logic [8:0]  ib, iw;
        logic [11:0] g;
        logic [63:0] inv;
        pix_out_t    o;
        ib = lv_in_black;
        iw = lv_in_white;
        g = lv_gamma;
        if (iw <= ib) iw = ib + 1;
        if (g < GAMMA_MIN) g = GAMMA_MIN;
        inv = ((64'd1 << 20) + (g >> 1)) / g;
        if (inv > 65535) inv = 65535;
        o.red_out   = adjust_channel(px.red_in, ib, iw, inv);
        o.green_out = adjust_channel(px.green_in, ib, iw, inv);
        o.blue_out  = adjust_channel(px.blue_in, ib, iw, inv);
        return o;
    endfunction

    initial begin
        logic [63:0] c;
        errors = 0;
        c = UNITY >> 1;
        for (int i = 1; i <= FB; i++) begin
            c = root_floor(c << FB);
            halving_coef[i] = c;
        end
    end

    assign pending = pixels_due.size();

    always @(posedge aclk) begin
        pix_out_t want;
        if (!aresetn) begin
            lv_in_black  <= IN_BLACK_RST;
            lv_in_white  <= IN_WHITE_RST;
            lv_gamma     <= GAMMA_Q8_RST;
            lv_out_black <= OUT_BLACK_RST;
            lv_out_white <= OUT_WHITE_RST;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    IDX_IN_BLACK:  lv_in_black  <= cfg_wdata[7:0];
                    IDX_IN_WHITE:  lv_in_white  <= cfg_wdata[7:0];
                    IDX_GAMMA_Q8:  lv_gamma     <= cfg_wdata;
                    IDX_OUT_BLACK: lv_out_black <= cfg_wdata[7:0];
                    IDX_OUT_WHITE: lv_out_white <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) pixels_due.push_back(adjust_pixel(s_data));
            if (m_valid && m_ready) begin
                if (pixels_due.size() == 0) begin
                    $error("output pixel %h with none expected", m_data);
                    errors++;
                end else begin
                    want = pixels_due.pop_front();
                    if (m_data.red_out !== want.red_out) begin
                        $error("red_out: expected %0d, got %0d", want.red_out, m_data.red_out);
                        errors++;
                    end
                    if (m_data.green_out !== want.green_out) begin
                        $error("green_out: expected %0d, got %0d",
                               want.green_out, m_data.green_out);
                        errors++;
                    end
                    if (m_data.blue_out !== want.blue_out) begin
                        $error("blue_out: expected %0d, got %0d", want.blue_out, m_data.blue_out);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

### tb/levels_gamma_pixel_adjust_test.sv
// Top of the levels and gamma pixel adjuster test: clock, reset, register
// writes, pixel stimulus with random gaps and stalls, watchdog and verdict.
// Depends on lgpa_pkg, the block and levels_gamma_pixel_adjust_check.
module levels_gamma_pixel_adjust_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lgpa_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 3 * FRAC_BITS_DEF + 20;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    pix_in_t               s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    pix_out_t              m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int                    errors, pending;
    int                    quiet_cycles = 0;
    bit                    no_gaps = 1'b0;
    logic [7:0]            cur_black = IN_BLACK_RST, cur_white = IN_WHITE_RST;

    always #5 aclk = ~aclk;

    levels_gamma_pixel_adjust DUT (.*);
    levels_gamma_pixel_adjust_check checker_i (.*);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("levels_gamma_pixel_adjust_test: errors");
            $finish;
        end
    end

    // Output side: random stall before each item, none during burst phases.
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            n = no_gaps ? 0 : $urandom_range(0, 11);
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    task automatic send_pixel(input pix_in_t px);
        int n;
        n = no_gaps ? 0 : $urandom_range(0, 11);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= px;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // Called at a falling edge with the block idle; also pokes an unused index.
    task automatic write_levels(input logic [11:0] ib, input logic [11:0] iw,
                                input logic [11:0] g, input logic [11:0] ob,
                                input logic [11:0] ow);
        logic [CFG_IDX_W-1:0] idx [5];
        logic [11:0]          val [5];
        idx = '{IDX_IN_BLACK, IDX_IN_WHITE, IDX_GAMMA_Q8, IDX_OUT_BLACK, IDX_OUT_WHITE};
        val = '{ib, iw, g, ob, ow};
        cfg_wr_en <= 1'b1;
        for (int i = 0; i < 5; i++) begin
            cfg_addr <= idx[i];
            cfg_wdata <= val[i];
            @(negedge aclk);
        end
        cfg_addr <= CFG_IDX_W'($urandom_range(5, 7));
        cfg_wdata <= 12'($urandom);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_black = ib[7:0];
        cur_white = iw[7:0];
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0: return cur_black;
            1: return cur_black + 8'd1;
            2: return cur_white;
            3: return cur_white - 8'd1;
            4: return ($urandom_range(0, 1) != 0) ? 8'd0 : 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        pix_in_t px;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset levels, field extremes and alternating bit patterns.
        send_pixel('{8'd0, 8'd255, 8'd128});
        send_pixel('{8'd255, 8'd0, 8'd1});
        send_pixel('{8'hAA, 8'h55, 8'hFE});
        send_pixel('{8'h55, 8'hAA, 8'h7F});
        drain();
        // White not above black, gamma below the floor, inverted output.
        write_levels(12'd255, 12'd0, 12'd0, 12'd255, 12'd0);
        send_pixel('{8'd0, 8'd254, 8'd255});
        send_pixel('{8'd100, 8'd200, 8'd255});
        drain();
        write_levels(12'd100, 12'd100, 12'd1, 12'd10, 12'd200);
        send_pixel('{8'd99, 8'd100, 8'd101});
        send_pixel('{8'd150, 8'd255, 8'd0});
        drain();
        // Largest gamma field and values wider than the 8-bit registers.
        write_levels(12'hF10, 12'hFF0, 12'hFFF, 12'h105, 12'hAFA);
        send_pixel('{8'd17, 8'd100, 8'd239});
        send_pixel('{8'd16, 8'd240, 8'd128});
        drain();
        write_levels(12'd0, 12'd255, 12'd26, 12'd0, 12'd255);
        send_pixel('{8'd1, 8'd64, 8'd254});
        send_pixel('{8'd2, 8'd128, 8'd200});
        drain();
        write_levels(12'd0, 12'd255, 12'd2560, 12'd255, 12'd0);
        send_pixel('{8'd1, 8'd64, 8'd254});
        send_pixel('{8'd2, 8'd128, 8'd200});
        drain();
        write_levels(12'd0, 12'd1, 12'd3, 12'd0, 12'd255);
        send_pixel('{8'd0, 8'd1, 8'd2});
        send_pixel('{8'd254, 8'd255, 8'd0});

        // Random phases, each with its own levels and an idle handover.
        for (int ph = 0; ph < 10; ph++) begin
            drain();
            if (ph % 3 == 0)
                write_levels(12'($urandom), 12'($urandom), 12'($urandom),
                             12'($urandom), 12'($urandom));
            else
                write_levels(12'($urandom_range(0, 120)), 12'($urandom_range(130, 255)),
                             12'($urandom_range(26, 2560)), 12'($urandom_range(0, 255)),
                             12'($urandom_range(0, 255)));
            no_gaps = (ph % 4 == 1);
            for (int i = 0; i < 75; i++) begin
                px.red_in = pick_level();
                px.green_in = pick_level();
                px.blue_in = pick_level();
                send_pixel(px);
            end
        end

        no_gaps = 1'b0;
        drain();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0) $display("levels_gamma_pixel_adjust_test: clean");
        else $display("levels_gamma_pixel_adjust_test: errors");
        $finish;
    end
endmodule

### levels_gamma_pixel_adjust.f
design/lgpa_pkg.sv
design/lgpa_inv_div.sv
design/lgpa_lane.sv
design/levels_gamma_pixel_adjust.sv
tb/levels_gamma_pixel_adjust_check.sv
tb/levels_gamma_pixel_adjust_test.sv
